[sv/udrb_pkg.sv]
// Shared types, codes and constants for the UART dual ring buffer.
package udrb_pkg;

    localparam int RING_DEPTH_DEF = 32;
    localparam int BYTE_W         = 8;
    localparam int LEVEL_W        = 7;
    localparam int COUNT_W        = 7;
    localparam int Q_DEPTH        = 2;

    typedef enum logic [1:0] {
        REQ_RX_BYTE    = 2'd0,
        REQ_HOST_READ  = 2'd1,
        REQ_HOST_WRITE = 2'd2,
        REQ_TX_READY   = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        KIND_HOST = 2'd0,
        KIND_TX   = 2'd1,
        KIND_ACK  = 2'd2
    } out_kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DROP  = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_ACK      = 3'd0,
        OP_RX_WRITE = 3'd1,
        OP_RX_READ  = 3'd2,
        OP_TX_WRITE = 3'd3,
        OP_TX_READ  = 3'd4
    } cmd_op_t;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_FETCH = 2'd1,
        BK_NEXT  = 2'd2
    } back_state_t;

    typedef struct packed {
        cmd_op_t              op;
        logic [BYTE_W-1:0]    data;
        logic [COUNT_W-1:0]   count;
        out_kind_t            kind;
        status_t              status;
        logic [LEVEL_W-1:0]   rx_level;
        logic [LEVEL_W-1:0]   tx_level;
        logic                 irq;
    } cmd_t;

    typedef struct packed {
        out_kind_t            kind;
        logic [BYTE_W-1:0]    data;
        logic                 has_byte;
        logic                 last;
        status_t              status;
        logic [LEVEL_W-1:0]   rx_level;
        logic [LEVEL_W-1:0]   tx_level;
        logic                 irq;
    } rsp_t;

endpackage

[sv/udrb_in_if.sv]
// Request channel interface: valid/ready plus one request item.
interface udrb_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic [6:0] read_max;

    modport source (output valid, output req_type, output data_byte, output read_max,
                    input ready);
    modport sink   (input valid, input req_type, input data_byte, input read_max,
                    output ready);
endinterface

[sv/udrb_out_if.sv]
// Result channel interface: valid/ready plus one result item.
interface udrb_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
    logic [1:0] status_code;
    logic [6:0] rx_level;
    logic [6:0] tx_level;
    logic       tx_irq_enable;

    modport source (output valid, output out_kind, output out_byte, output out_valid,
                    output out_last, output status_code, output rx_level,
                    output tx_level, output tx_irq_enable, input ready);
    modport sink   (input valid, input out_kind, input out_byte, input out_valid,
                    input out_last, input status_code, input rx_level,
                    input tx_level, input tx_irq_enable, output ready);
endinterface

[sv/udrb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module udrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

[sv/udrb_front.sv]
// Front end: accepts requests, tracks fill levels and irq enable, builds commands.
module udrb_front
    import udrb_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    udrb_in_if.sink      req,
    input  logic         q_full,
    output logic         q_push,
    output cmd_t         q_cmd
);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);

    logic [FILL_W-1:0] rx_fill_reg, rx_fill_next;
    logic [FILL_W-1:0] tx_fill_reg, tx_fill_next;
    logic              irq_reg, irq_next;
    logic [COUNT_W-1:0] rx_fill_ext;
    logic [COUNT_W-1:0] pop_n;
    req_type_t          rtype;

    assign req.ready   = !q_full;
    assign q_push      = req.valid && !q_full;
    assign rtype       = req_type_t'(req.req_type);
    assign rx_fill_ext = COUNT_W'(rx_fill_reg);
    assign pop_n       = (req.read_max < rx_fill_ext) ? req.read_max : rx_fill_ext;

    always_comb
    begin
        rx_fill_next = rx_fill_reg;
        tx_fill_next = tx_fill_reg;
        irq_next     = irq_reg;
        q_cmd.op     = OP_ACK;
        q_cmd.data   = req.data_byte;
        q_cmd.count  = pop_n;
        q_cmd.kind   = KIND_ACK;
        q_cmd.status = ST_OK;
        unique case (rtype)
            REQ_RX_BYTE:
            begin
                if (rx_fill_reg < FILL_W'(RING_DEPTH))
                begin
                    q_cmd.op     = OP_RX_WRITE;
                    rx_fill_next = rx_fill_reg + 1'b1;
                end
                else
                begin
                    q_cmd.status = ST_DROP;
                end
            end
            REQ_HOST_READ:
            begin
                q_cmd.kind = KIND_HOST;
                if (pop_n == '0)
                begin
                    q_cmd.status = ST_EMPTY;
                end
                else
                begin
                    q_cmd.op     = OP_RX_READ;
                    rx_fill_next = rx_fill_reg - FILL_W'(pop_n);
                end
            end
            REQ_HOST_WRITE:
            begin
                if (tx_fill_reg >= FILL_W'(RING_DEPTH))
                begin
                    q_cmd.status = ST_FULL;
                end
                else
                begin
                    q_cmd.op     = OP_TX_WRITE;
                    tx_fill_next = tx_fill_reg + 1'b1;
                    irq_next     = 1'b1;
                end
            end
            REQ_TX_READY:
            begin
                if (tx_fill_reg != '0)
                begin
                    q_cmd.op     = OP_TX_READ;
                    q_cmd.kind   = KIND_TX;
                    q_cmd.count  = COUNT_W'(1);
                    tx_fill_next = tx_fill_reg - 1'b1;
                end
                else
                begin
                    q_cmd.status = ST_EMPTY;
                    irq_next     = 1'b0;
                end
            end
        endcase
        q_cmd.rx_level = LEVEL_W'(rx_fill_next);
        q_cmd.tx_level = LEVEL_W'(tx_fill_next);
        q_cmd.irq      = irq_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_fill_reg <= '0;
            tx_fill_reg <= '0;
            irq_reg     <= 1'b0;
        end
        else if (q_push)
        begin
            rx_fill_reg <= rx_fill_next;
            tx_fill_reg <= tx_fill_next;
            irq_reg     <= irq_next;
        end
    end
endmodule

[sv/udrb_cmd_queue.sv]
// Short command queue between front and back end.
module udrb_cmd_queue
    import udrb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t head
);
    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    cmd_t             entry_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full      = (cnt_reg == CNT_W'(Q_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("command queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
        else $error("command queue pop while empty");
endmodule

[sv/udrb_back.sv]
// Back end: ring pointers, ring RAMs and the result output register.
module udrb_back
    import udrb_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_pop,
    udrb_out_if.source  rsp
);
    localparam int PTR_W = $clog2(RING_DEPTH);

    back_state_t        state_reg, state_next;
    logic [COUNT_W-1:0] remain_reg, remain_next;
    logic [PTR_W-1:0]   rx_wr_reg, rx_wr_next, rx_rd_reg, rx_rd_next;
    logic [PTR_W-1:0]   tx_wr_reg, tx_wr_next, tx_rd_reg, tx_rd_next;
    logic               out_valid_reg, out_valid_next;
    rsp_t               out_reg, out_next;
    logic               out_free;
    logic               rx_we, rx_re, tx_we, tx_re;
    logic [BYTE_W-1:0]  rx_rdata, tx_rdata;
    rsp_t               ack_rsp;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    udrb_ram #(.WIDTH(BYTE_W), .DEPTH(RING_DEPTH)) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_wr_reg),
        .wdata (cmd.data),
        .re    (rx_re),
        .raddr (rx_rd_reg),
        .rdata (rx_rdata)
    );

    udrb_ram #(.WIDTH(BYTE_W), .DEPTH(RING_DEPTH)) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_wr_reg),
        .wdata (cmd.data),
        .re    (tx_re),
        .raddr (tx_rd_reg),
        .rdata (tx_rdata)
    );

    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        ack_rsp.kind     = cmd.kind;
        ack_rsp.data     = '0;
        ack_rsp.has_byte = 1'b0;
        ack_rsp.last     = 1'b1;
        ack_rsp.status   = cmd.status;
        ack_rsp.rx_level = cmd.rx_level;
        ack_rsp.tx_level = cmd.tx_level;
        ack_rsp.irq      = cmd.irq;
    end

    always_comb
    begin
        state_next     = state_reg;
        remain_next    = remain_reg;
        rx_wr_next     = rx_wr_reg;
        rx_rd_next     = rx_rd_reg;
        tx_wr_next     = tx_wr_reg;
        tx_rd_next     = tx_rd_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_next       = out_reg;
        cmd_pop        = 1'b0;
        rx_we          = 1'b0;
        rx_re          = 1'b0;
        tx_we          = 1'b0;
        tx_re          = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    unique case (cmd.op)
                        OP_RX_WRITE:
                        begin
                            rx_we          = 1'b1;
                            rx_wr_next     = ptr_inc(rx_wr_reg);
                            out_valid_next = 1'b1;
                            out_next       = ack_rsp;
                            cmd_pop        = 1'b1;
                        end
                        OP_TX_WRITE:
                        begin
                            tx_we          = 1'b1;
                            tx_wr_next     = ptr_inc(tx_wr_reg);
                            out_valid_next = 1'b1;
                            out_next       = ack_rsp;
                            cmd_pop        = 1'b1;
                        end
                        OP_RX_READ:
                        begin
                            rx_re       = 1'b1;
                            rx_rd_next  = ptr_inc(rx_rd_reg);
                            remain_next = cmd.count - 1'b1;
                            state_next  = BK_FETCH;
                        end
                        OP_TX_READ:
                        begin
                            tx_re       = 1'b1;
                            tx_rd_next  = ptr_inc(tx_rd_reg);
                            remain_next = cmd.count - 1'b1;
                            state_next  = BK_FETCH;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_next       = ack_rsp;
                            cmd_pop        = 1'b1;
                        end
                    endcase
                end
            end
            BK_FETCH:
            begin
                // RAM data of the read issued last cycle; output slot is empty here
                out_valid_next    = 1'b1;
                out_next          = ack_rsp;
                out_next.data     = (cmd.op == OP_TX_READ) ? tx_rdata : rx_rdata;
                out_next.has_byte = 1'b1;
                out_next.last     = (remain_reg == '0);
                if (remain_reg == '0)
                begin
                    cmd_pop    = 1'b1;
                    state_next = BK_IDLE;
                end
                else
                begin
                    state_next = BK_NEXT;
                end
            end
            BK_NEXT:
            begin
                // only host reads pop more than one byte
                if (out_free)
                begin
                    rx_re       = 1'b1;
                    rx_rd_next  = ptr_inc(rx_rd_reg);
                    remain_next = remain_reg - 1'b1;
                    state_next  = BK_FETCH;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
        end
        else
        begin
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg    <= '0;
            rx_wr_reg     <= '0;
            rx_rd_reg     <= '0;
            tx_wr_reg     <= '0;
            tx_rd_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            remain_reg    <= remain_next;
            rx_wr_reg     <= rx_wr_next;
            rx_rd_reg     <= rx_rd_next;
            tx_wr_reg     <= tx_wr_next;
            tx_rd_reg     <= tx_rd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.out_kind      = out_reg.kind;
    assign rsp.out_byte      = out_reg.data;
    assign rsp.out_valid     = out_reg.has_byte;
    assign rsp.out_last      = out_reg.last;
    assign rsp.status_code   = out_reg.status;
    assign rsp.rx_level      = out_reg.rx_level;
    assign rsp.tx_level      = out_reg.tx_level;
    assign rsp.tx_irq_enable = out_reg.irq;

    a_fetch_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_FETCH |-> !out_valid_reg)
        else $error("read data arrived with output register occupied");
    a_read_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_IDLE && cmd_valid && (cmd.op == OP_RX_READ || cmd.op == OP_TX_READ)
        |-> cmd.count != '0)
        else $error("read command with zero count");
    a_last_ends_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_FETCH && remain_reg == '0 |=> state_reg == BK_IDLE && out_valid_reg)
        else $error("final byte did not retire the command");
endmodule

[sv/uart_dual_ring_buffer_unit.sv]
// Top level of the UART dual ring buffer: front end, command queue, back end.
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+------------------------------------------------
//  req     | in  | valid/ready  | req_type, data_byte, read_max
//  rsp     | out | valid/ready  | out_kind, out_byte, out_valid, out_last,
//          |     |              | status_code, rx_level, tx_level, tx_irq_enable
//
// Push and acknowledge-only requests retire at one transaction per cycle while
// rsp is not stalled; the back end emits the single result the cycle after it
// takes the command. A popped byte passes through the registered ring RAM read,
// then the output register; the next byte's read waits for a free output slot.
// Reset clears pointers, fill levels, irq enable and queue; ring RAM contents
// are left as they are, since fill levels keep every read on a written entry.
// The 2-entry command queue lets the front keep accepting while the back end
// waits on a stalled result; req.ready drops only when that queue is full.
module uart_dual_ring_buffer_unit
    import udrb_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    udrb_in_if.sink     req,
    udrb_out_if.source  rsp
);
    logic q_push, q_full, q_pop, q_not_empty;
    cmd_t q_in_cmd, q_head;

    // front: classifies each request, owns fill counts so levels are final at entry
    udrb_front #(.RING_DEPTH(RING_DEPTH)) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (q_in_cmd)
    );

    udrb_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_in_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // back: ring pointers and RAMs, one result transaction per byte popped
    udrb_back #(.RING_DEPTH(RING_DEPTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_not_empty),
        .cmd       (q_head),
        .cmd_pop   (q_pop),
        .rsp       (rsp)
    );
endmodule
